FILE: rtl/core/stp_pkg.sv
// shared types and constants of the software timer pool
package stp_pkg;

   localparam int SLOT_FIELD_W = 4;
   localparam int TICK_W       = 32;
   localparam int QUEUE_DEPTH  = 2;
   localparam int QPTR_W       = 1;
   localparam int QCNT_W       = 2;

   typedef enum logic [1:0] {
      OP_CREATE  = 2'd0,
      OP_DELETE  = 2'd1,
      OP_POLL    = 2'd2,
      OP_RESTART = 2'd3
   } opcode_type;

   typedef struct packed {
      opcode_type              opcode;
      logic [SLOT_FIELD_W-1:0] slot;
      logic [TICK_W-1:0]       period;
      logic                    one_shot;
      logic [TICK_W-1:0]       now;
   } req_type;

   typedef struct packed {
      logic                    fired;
      logic [SLOT_FIELD_W-1:0] new_slot;
      logic                    create_failed;
   } rsp_type;

   // classified command passed from front to back
   typedef struct packed {
      opcode_type              opcode;
      logic [SLOT_FIELD_W-1:0] slot;
      logic                    slot_ok;
      logic                    period_zero;
      logic [TICK_W-1:0]       period;
      logic                    one_shot;
      logic [TICK_W-1:0]       now;
   } cmd_type;

   typedef enum logic {
      BK_IDLE = 1'b0,
      BK_EXEC = 1'b1
   } back_state_type;

endpackage

FILE: rtl/core/stp_front.sv
// request intake register and command classification
module stp_front import stp_pkg::*; #(
   parameter int SLOTS = 8
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    cmd_valid,
   input  logic    cmd_full,
   output cmd_type cmd_data
);

   logic    valid_ff, valid_in;
   cmd_type cmd_ff, cmd_in;
   logic    take;

   assign req_stall = valid_ff & cmd_full;
   assign take      = req_valid & ~req_stall;

   always_comb begin
      cmd_in             = cmd_ff;
      valid_in           = valid_ff;
      if (valid_ff && !cmd_full) begin
         valid_in = 1'b0;
      end
      if (take) begin
         valid_in            = 1'b1;
         cmd_in.opcode       = req_data.opcode;
         cmd_in.slot         = req_data.slot;
         // slot numbers past the pool size are ignored downstream
         cmd_in.slot_ok      = ({1'b0, req_data.slot} < (SLOT_FIELD_W + 1)'(SLOTS));
         cmd_in.period_zero  = (req_data.period == '0);
         cmd_in.period       = req_data.period;
         cmd_in.one_shot     = req_data.one_shot;
         cmd_in.now          = req_data.now;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      cmd_ff <= cmd_in;
   end

   assign cmd_valid = valid_ff;
   assign cmd_data  = cmd_ff;

endmodule

FILE: rtl/core/stp_queue.sv
// short command queue between front and back
module stp_queue import stp_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_data,
   output logic    full,
   output logic    not_empty,
   input  logic    pop,
   output cmd_type pop_data
);

   cmd_type             mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                do_push, do_pop;

   assign full      = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign do_push   = push & ~full;
   assign do_pop    = pop & not_empty;
   assign pop_data  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: rtl/core/stp_back.sv
// slot state, command execution and result register
module stp_back import stp_pkg::*; #(
   parameter int SLOTS = 8
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    cmd_avail,
   input  cmd_type cmd_data,
   output logic    cmd_pop,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   back_state_type     state_ff, state_in;
   logic [SLOTS-1:0]   active_ff, active_in;
   cmd_type            cmd_ff;
   logic [IDX_W-1:0]   addr_ff, addr_in;
   logic               found_ff, found_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   logic [TICK_W-1:0]  period_mem [SLOTS];
   logic [TICK_W-1:0]  expiry_mem [SLOTS];
   logic               one_shot_mem [SLOTS];
   logic [TICK_W-1:0]  per_rd_ff, exp_rd_ff;
   logic               os_rd_ff;

   logic               rd_en, done;
   logic               wr_create, wr_expiry;
   logic [TICK_W-1:0]  sum_a, sum_b, sum, diff;
   logic               is_active;

   // lowest free slot
   always_comb begin
      found_in = 1'b0;
      addr_in  = IDX_W'(cmd_data.slot);
      if (cmd_data.opcode == OP_CREATE) begin
         addr_in = '0;
         for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!active_ff[i]) begin
               found_in = 1'b1;
               addr_in  = IDX_W'(i);
            end
         end
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: begin
            if (cmd_avail) state_in = BK_EXEC;
         end
         BK_EXEC: begin
            if (!rsp_valid_ff || !rsp_stall) state_in = BK_IDLE;
         end
         default: state_in = BK_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      cmd_pop = 1'b0;
      rd_en   = 1'b0;
      done    = 1'b0;
      case (state_ff)
         BK_IDLE: begin
            cmd_pop = cmd_avail;
            rd_en   = cmd_avail;
         end
         BK_EXEC: begin
            done = ~rsp_valid_ff | ~rsp_stall;
         end
         default: begin
            cmd_pop = 1'b0;
         end
      endcase
   end

   assign is_active = active_ff[addr_ff];
   assign sum_a     = (cmd_ff.opcode == OP_POLL) ? exp_rd_ff : cmd_ff.now;
   assign sum_b     = (cmd_ff.opcode == OP_CREATE) ? cmd_ff.period : per_rd_ff;
   assign sum       = sum_a + sum_b;
   assign diff      = cmd_ff.now - exp_rd_ff;

   // execute
   always_comb begin
      active_in = active_ff;
      wr_create = 1'b0;
      wr_expiry = 1'b0;
      rsp_in    = '0;
      case (cmd_ff.opcode)
         OP_CREATE: begin
            if (!cmd_ff.period_zero && found_ff) begin
               wr_create          = 1'b1;
               wr_expiry          = 1'b1;
               active_in[addr_ff] = 1'b1;
               rsp_in.new_slot    = SLOT_FIELD_W'(addr_ff);
            end else begin
               rsp_in.create_failed = 1'b1;
            end
         end
         OP_DELETE: begin
            if (cmd_ff.slot_ok) active_in[addr_ff] = 1'b0;
         end
         OP_POLL: begin
            if (cmd_ff.slot_ok && is_active && !diff[TICK_W-1]) begin
               rsp_in.fired = 1'b1;
               if (os_rd_ff) begin
                  active_in[addr_ff] = 1'b0;
               end else begin
                  wr_expiry = 1'b1;
               end
            end
         end
         OP_RESTART: begin
            if (cmd_ff.slot_ok && is_active) wr_expiry = 1'b1;
         end
         default: begin
            rsp_in = '0;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (done) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         active_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (done) active_ff <= active_in;
      end
      if (cmd_pop) begin
         cmd_ff   <= cmd_data;
         addr_ff  <= addr_in;
         found_ff <= found_in;
      end
      if (done) rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (done && wr_create) period_mem[addr_ff] <= cmd_ff.period;
      if (rd_en) per_rd_ff <= period_mem[addr_in];
   end

   always_ff @(posedge clock) begin
      if (done && wr_expiry) expiry_mem[addr_ff] <= sum;
      if (rd_en) exp_rd_ff <= expiry_mem[addr_in];
   end

   always_ff @(posedge clock) begin
      if (done && wr_create) one_shot_mem[addr_ff] <= cmd_ff.one_shot;
      if (rd_en) os_rd_ff <= one_shot_mem[addr_in];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_create_marks_active: assert property (@(posedge clock) disable iff (reset)
      (done && wr_create) |=> active_ff[$past(addr_ff)])
      else $error("created slot not active");

   a_delete_frees: assert property (@(posedge clock) disable iff (reset)
      (done && cmd_ff.opcode == OP_DELETE && cmd_ff.slot_ok) |=> !active_ff[$past(addr_ff)])
      else $error("deleted slot still active");

   a_result_from_exec: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == BK_EXEC))
      else $error("result raised outside execute");

   a_fire_needs_active: assert property (@(posedge clock) disable iff (reset)
      (done && rsp_in.fired) |-> is_active)
      else $error("inactive slot fired");

endmodule

FILE: rtl/core/software_timer_pool_top.sv
// software timer pool top level: front, command queue and execution back end
// path: front register, queue entry, back end command register, result register
// items: the back end starts a new item only after its read then execute-and-write
//    pass over the slot memories for the last one is through
// reset: synchronous, active high; clears all slots to free, empties the queue
//    and drops any pending result; no clearing pass is needed
module software_timer_pool_top import stp_pkg::*; #(
   parameter int SLOTS = 8
) (
   input  logic    clock,
   input  logic    reset,
   // request items
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   // result items
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   // front to queue
   logic    front_valid;
   cmd_type front_cmd;
   logic    q_full;

   // queue to back
   logic    q_not_empty;
   logic    q_pop;
   cmd_type q_cmd;

   // front registers the item and flags out-of-range slots and zero periods
   stp_front #(
      .SLOTS (SLOTS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .cmd_valid (front_valid),
      .cmd_full  (q_full),
      .cmd_data  (front_cmd)
   );

   // two-entry queue lets intake keep going while the back end is busy
   stp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (front_valid),
      .push_data (front_cmd),
      .full      (q_full),
      .not_empty (q_not_empty),
      .pop       (q_pop),
      .pop_data  (q_cmd)
   );

   // back end owns slot state: active bits, period, expiry and one-shot memories
   stp_back #(
      .SLOTS (SLOTS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_avail (q_not_empty),
      .cmd_data  (q_cmd),
      .cmd_pop   (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

FILE: sim/software_timer_pool_checker.sv
// result checker for the software timer pool: slot state predictor and item comparison
`timescale 1ns / 100ps
module timer_pool_checker import stp_pkg::*; #(
   parameter int SLOTS = 8
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_stall,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_stall,
   input  rsp_type rsp_data,
   output int      failures,
   output int      outstanding
);

   // predicted slot state, a zero period marks a free slot
   logic [TICK_W-1:0] armed_period [SLOTS];
   logic [TICK_W-1:0] due_tick     [SLOTS];
   logic              fire_once    [SLOTS];
   rsp_type           due_results  [$];

   function automatic rsp_type pool_response(input req_type item);
      rsp_type           res;
      logic [TICK_W-1:0] lag;
      logic              in_range;
      logic              placed;
      res      = '0;
      in_range = (item.slot < SLOTS);
      placed   = 1'b0;
      case (item.opcode)
         OP_CREATE: begin
            if (item.period != '0) begin
               for (int i = 0; i < SLOTS; i++) begin
                  if (!placed && armed_period[i] == '0) begin
                     armed_period[i] = item.period;
                     due_tick[i]     = item.now + item.period;
                     fire_once[i]    = item.one_shot;
                     res.new_slot    = SLOT_FIELD_W'(i);
                     placed          = 1'b1;
                  end
               end
            end
            res.create_failed = !placed;
         end
         OP_DELETE: begin
            if (in_range)
               armed_period[item.slot] = '0;
         end
         OP_POLL: begin
            if (in_range && armed_period[item.slot] != '0) begin
               // expired when now minus expiry is non-negative as a signed value
               lag = item.now - due_tick[item.slot];
               if (!lag[TICK_W-1]) begin
                  res.fired = 1'b1;
                  if (fire_once[item.slot])
                     armed_period[item.slot] = '0;
                  else
                     due_tick[item.slot] = due_tick[item.slot] + armed_period[item.slot];
               end
            end
         end
         default: begin
            if (in_range && armed_period[item.slot] != '0)
               due_tick[item.slot] = item.now + armed_period[item.slot];
         end
      endcase
      return res;
   endfunction

   always @(posedge clock) begin : watch
      rsp_type want;
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) begin
            armed_period[i] = '0;
            due_tick[i]     = '0;
            fire_once[i]    = 1'b0;
         end
         due_results.delete();
         failures = 0;
      end else begin
         if (req_valid && !req_stall)
            due_results.push_back(pool_response(req_data));
         if (rsp_valid && !rsp_stall) begin
            if (due_results.size() == 0) begin
               $error("result item with no request outstanding");
               failures++;
            end else begin
               want = due_results.pop_front();
               if (rsp_data.fired !== want.fired) begin
                  $error("fired: expected %0d, got %0d", want.fired, rsp_data.fired);
                  failures++;
               end
               if (rsp_data.new_slot !== want.new_slot) begin
                  $error("new_slot: expected %0d, got %0d", want.new_slot, rsp_data.new_slot);
                  failures++;
               end
               if (rsp_data.create_failed !== want.create_failed) begin
                  $error("create_failed: expected %0d, got %0d",
                         want.create_failed, rsp_data.create_failed);
                  failures++;
               end
            end
         end
      end
      outstanding = due_results.size();
   end

endmodule

FILE: sim/testbench.sv
// top of the software timer pool testbench: clock, reset, stimulus and verdict
`timescale 1ns / 100ps
module testbench;
   import stp_pkg::*;

   localparam int SLOTS        = 8;
   localparam int RANDOM_ITEMS = 930;
   localparam int HOLD_CYCLES  = 120;
   localparam int DRAIN_CYCLES = 20;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   // calm switches idling off on both sides for a stretch of the run
   logic calm          = 1'b0;
   // one long receiver hold-off, asked for by the sender, counted by the receiver
   logic long_hold_req = 1'b0;
   logic hold_taken    = 1'b0;
   int   hold_left     = 0;
   int   failures;
   int   outstanding;

   software_timer_pool_top #(.SLOTS(SLOTS)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   timer_pool_checker #(.SLOTS(SLOTS)) checker_inst (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .failures    (failures),
      .outstanding (outstanding)
   );

   // 10 ns clock
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // result side: random stall, one long hold-off so the block backs up into its input
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (long_hold_req && !hold_taken) begin
         hold_taken <= 1'b1;
         hold_left  <= HOLD_CYCLES;
         rsp_stall  <= 1'b1;
      end else begin
         rsp_stall <= !calm && ($urandom_range(0, 99) < 26);
      end
   end

   // offer one request item, with random idle cycles ahead of it, and wait for acceptance
   task automatic offer(input opcode_type op, input logic [SLOT_FIELD_W-1:0] slot,
                        input logic [TICK_W-1:0] period, input logic one_shot,
                        input logic [TICK_W-1:0] now);
      req_type item;
      item.opcode   = op;
      item.slot     = slot;
      item.period   = period;
      item.one_shot = one_shot;
      item.now      = now;
      while (!calm && $urandom_range(0, 99) < 26) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
   endtask

   // safety net against a hung handshake
   initial begin
      #5_000_000;
      $display("software_timer_pool_top regression: fail");
      $finish;
   end

   initial begin : stimulus
      logic [TICK_W-1:0]       tick;
      logic [TICK_W-1:0]       when;
      logic [TICK_W-1:0]       period;
      logic [SLOT_FIELD_W-1:0] slot;
      int                      pick;
      int                      sel;

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed: zero period is refused
      offer(OP_CREATE, 4'd3, 32'd0, 1'b0, 32'd0);
      // fill the pool; one-shot slot 0 expires exactly at the wrap to zero
      offer(OP_CREATE, 4'd0, 32'd1, 1'b1, 32'hFFFF_FFFF);
      offer(OP_CREATE, 4'd15, 32'hFFFF_FFFF, 1'b0, 32'd0);
      offer(OP_CREATE, 4'd9, 32'd10, 1'b0, 32'd100);
      offer(OP_CREATE, 4'd5, 32'h8000_0000, 1'b1, 32'd0);
      offer(OP_CREATE, 4'd15, 32'd5, 1'b0, 32'd100);
      offer(OP_CREATE, 4'd0, 32'd5, 1'b1, 32'd100);
      offer(OP_CREATE, 4'd7, 32'd5, 1'b0, 32'd100);
      offer(OP_CREATE, 4'd12, 32'd5, 1'b1, 32'd100);
      // full pool
      offer(OP_CREATE, 4'd0, 32'd7, 1'b0, 32'd100);
      // one-shot fires at zero distance, then the slot is free
      offer(OP_POLL, 4'd0, $urandom, 1'b1, 32'd0);
      offer(OP_POLL, 4'd0, $urandom, 1'b0, 32'd0);
      // periodic: one tick early, then on time, then reloaded without drift
      offer(OP_POLL, 4'd2, $urandom, 1'b0, 32'd109);
      offer(OP_POLL, 4'd2, $urandom, 1'b1, 32'd110);
      // half-range distance: just short of the sign flip and just past it
      offer(OP_POLL, 4'd3, $urandom, 1'b0, 32'h7FFF_FFFF);
      offer(OP_POLL, 4'd3, $urandom, 1'b0, 32'hFFFF_FFFF);
      // restart an active slot, then an inactive one
      offer(OP_RESTART, 4'd2, $urandom, 1'b1, 32'd200);
      offer(OP_POLL, 4'd2, $urandom, 1'b0, 32'd209);
      offer(OP_RESTART, 4'd0, $urandom, 1'b0, 32'd0);
      // slot numbers beyond the pool do nothing
      offer(OP_DELETE, 4'd9, $urandom, 1'b1, 32'd0);
      offer(OP_POLL, 4'd15, $urandom, 1'b0, 32'hFFFF_FFFF);
      offer(OP_RESTART, 4'd8, $urandom, 1'b1, 32'd300);
      // delete an active slot, then the same slot again while free
      offer(OP_DELETE, 4'd1, $urandom, 1'b0, 32'd0);
      offer(OP_DELETE, 4'd1, $urandom, 1'b1, 32'd0);
      // create takes the lowest free slot
      offer(OP_CREATE, 4'd6, 32'd3, 1'b0, 32'd400);

      // random: a running tick with small steps so polls land around expiry,
      // with some noise from fully random times and out-of-range slots
      tick = $urandom;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == 150)
            long_hold_req <= 1'b1;
         if (n == 400)
            calm <= 1'b1;
         if (n == 560)
            calm <= 1'b0;
         // now and then run the tick across the 32-bit wrap
         if (n % 240 == 120)
            tick = 32'hFFFF_FFC0;
         tick = tick + $urandom_range(0, 6);
         when = ($urandom_range(0, 99) < 8) ? $urandom : tick;
         slot = ($urandom_range(0, 9) == 0) ? SLOT_FIELD_W'($urandom_range(8, 15))
                                            : SLOT_FIELD_W'($urandom_range(0, SLOTS - 1));
         pick = $urandom_range(0, 99);
         if (pick < 30) begin
            sel = $urandom_range(0, 99);
            if (sel < 4)
               period = '0;
            else if (sel < 14)
               period = $urandom;
            else
               period = $urandom_range(1, 40);
            offer(OP_CREATE, SLOT_FIELD_W'($urandom), period, 1'($urandom), when);
         end else if (pick < 68) begin
            offer(OP_POLL, slot, $urandom, 1'($urandom), when);
         end else if (pick < 82) begin
            offer(OP_RESTART, slot, $urandom, 1'($urandom), when);
         end else begin
            offer(OP_DELETE, slot, $urandom, 1'($urandom), when);
         end
      end
      req_valid <= 1'b0;

      // drain: every result back, then an extra wait for strays
      @(posedge clock);
      wait (outstanding == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0)
         $display("software_timer_pool_top regression: pass");
      else
         $display("software_timer_pool_top regression: fail");
      $finish;
   end

endmodule
